### rtl/core/rgb_to_yuv420_planar_macros.svh
// ----------------------------------------------------------------------------
// rgb_to_yuv420_planar assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_PLANAR_MACROS_SVH
`define RGB_TO_YUV420_PLANAR_MACROS_SVH

// Condition on the left implies the condition on the right in the same cycle.
`define R2Y_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Condition on the left implies the condition on the right in the next cycle.
`define R2Y_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rgb2yuv_pkg.sv
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Types, constants and helpers shared by the RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgb2yuv_pkg;

    localparam int DATA_W         = 32;
    localparam int ADDR_W         = 3;
    localparam int CFG_W          = 13;
    localparam int SIZE_W         = 14;
    localparam int LUMA_W         = 24;
    localparam int CHROMA_W       = 22;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_Q_DEPTH    = 4;
    localparam int PROD_W         = 27;
    localparam int ACC_W          = 29;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

    // Q16 coefficients
    localparam logic signed [17:0] Q_YR = 18'sd19595;
    localparam logic signed [17:0] Q_YG = 18'sd38470;
    localparam logic signed [17:0] Q_YB = 18'sd7471;
    localparam logic signed [17:0] Q_UR = -18'sd11076;
    localparam logic signed [17:0] Q_UG = -18'sd21758;
    localparam logic signed [17:0] Q_UB = 18'sd32768;
    localparam logic signed [17:0] Q_VR = 18'sd32768;
    localparam logic signed [17:0] Q_VG = -18'sd27460;
    localparam logic signed [17:0] Q_VB = -18'sd5308;
    localparam logic signed [ACC_W-1:0] Q_HALF = 29'sd8388608;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } t_plane;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        t_plane            plane;
        logic [7:0]        sample_value;
        logic [LUMA_W-1:0] plane_offset;
        logic              last_of_item;
        logic              frame_end;
    } t_result;

    // One converted pixel waiting for the output side
    typedef struct packed {
        logic [7:0]          y;
        logic [7:0]          u;
        logic [7:0]          v;
        logic [LUMA_W-1:0]   luma_off;
        logic [CHROMA_W-1:0] chroma_off;
        logic                chroma;
        logic                frame_end;
    } t_job;

    // Clamp to 2..maxv, then round down to even
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] s;
        s = SIZE_W'(v);
        if (s < SIZE_W'(2)) s = SIZE_W'(2);
        if (s > maxv) s = maxv;
        s[0] = 1'b0;
        if (s < SIZE_W'(2)) s = SIZE_W'(2);
        return s;
    endfunction

    // Q16 accumulator to 0..255
    function automatic logic [7:0] to_sample(input logic signed [ACC_W-1:0] acc);
        logic [7:0] s;
        if (acc[ACC_W-1]) s = 8'd0;
        else if (|acc[ACC_W-2:24]) s = 8'hFF;
        else s = acc[23:16];
        return s;
    endfunction

endpackage

### rtl/core/rgb2yuv_front.sv
// ----------------------------------------------------------------------------
// rgb2yuv_front
// Accepts pixels, tracks raster position and plane offsets, and converts
// each pixel in two stages (products, then sums with clamping).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb2yuv_front
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_width,
    input  logic [SIZE_W-1:0] i_height,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_pixel            i_pixel,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output t_job              o_job
);

    localparam int COL_W = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

    logic [COL_W-1:0]    r_column;
    logic [ROW_W-1:0]    r_row;
    logic [LUMA_W-1:0]   r_luma_idx;
    logic [CHROMA_W-1:0] r_chroma_idx;

    logic r_s1_v, r_s2_v;
    logic s1_free, s2_free, accept;
    logic row_end, frame_end, chroma;

    logic signed [PROD_W-1:0] r_yr, r_yg, r_yb, r_ur, r_ug, r_ub, r_vr, r_vg, r_vb;
    logic [LUMA_W-1:0]   r_s1_luma;
    logic [CHROMA_W-1:0] r_s1_chroma_off;
    logic                r_s1_chroma, r_s1_fend;
    t_job                r_job;

    logic signed [8:0] red_s, green_s, blue_s;
    logic signed [ACC_W-1:0] acc_y, acc_u, acc_v;

    assign s2_free = !r_s2_v || i_job_ready;
    assign s1_free = !r_s1_v || s2_free;
    assign o_ready = s1_free;
    assign accept  = i_valid && s1_free;

    assign row_end   = (SIZE_W'(r_column) + SIZE_W'(1)) >= i_width;
    assign frame_end = row_end && ((SIZE_W'(r_row) + SIZE_W'(1)) >= i_height);
    assign chroma    = !r_row[0] && !r_column[0];

    assign red_s   = $signed({1'b0, i_pixel.red});
    assign green_s = $signed({1'b0, i_pixel.green});
    assign blue_s  = $signed({1'b0, i_pixel.blue});

    assign acc_y = ACC_W'(r_yr) + ACC_W'(r_yg) + ACC_W'(r_yb);
    assign acc_u = ACC_W'(r_ur) + ACC_W'(r_ug) + ACC_W'(r_ub) + Q_HALF;
    assign acc_v = ACC_W'(r_vr) + ACC_W'(r_vg) + ACC_W'(r_vb) + Q_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column     <= '0;
            r_row        <= '0;
            r_luma_idx   <= '0;
            r_chroma_idx <= '0;
            r_s1_v       <= 1'b0;
            r_s2_v       <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= accept;
            end
            if (s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (accept) begin
                if (frame_end) begin
                    r_column     <= '0;
                    r_row        <= '0;
                    r_luma_idx   <= '0;
                    r_chroma_idx <= '0;
                end else begin
                    r_luma_idx <= r_luma_idx + 1'b1;
                    if (chroma) begin
                        r_chroma_idx <= r_chroma_idx + 1'b1;
                    end
                    if (row_end) begin
                        r_column <= '0;
                        r_row    <= r_row + 1'b1;
                    end else begin
                        r_column <= r_column + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_yr            <= red_s   * Q_YR;
            r_yg            <= green_s * Q_YG;
            r_yb            <= blue_s  * Q_YB;
            r_ur            <= red_s   * Q_UR;
            r_ug            <= green_s * Q_UG;
            r_ub            <= blue_s  * Q_UB;
            r_vr            <= red_s   * Q_VR;
            r_vg            <= green_s * Q_VG;
            r_vb            <= blue_s  * Q_VB;
            r_s1_luma       <= r_luma_idx;
            r_s1_chroma_off <= r_chroma_idx;
            r_s1_chroma     <= chroma;
            r_s1_fend       <= frame_end;
        end
        if (s2_free && r_s1_v) begin
            r_job.y          <= to_sample(acc_y);
            r_job.u          <= to_sample(acc_u);
            r_job.v          <= to_sample(acc_v);
            r_job.luma_off   <= r_s1_luma;
            r_job.chroma_off <= r_s1_chroma_off;
            r_job.chroma     <= r_s1_chroma;
            r_job.frame_end  <= r_s1_fend;
        end
    end

    assign o_job_valid = r_s2_v;
    assign o_job       = r_job;

endmodule

### rtl/core/rgb2yuv_queue.sv
// ----------------------------------------------------------------------------
// rgb2yuv_queue
// Small FIFO of converted pixels between the front and back sections.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb2yuv_queue
    import rgb2yuv_pkg::*;
#(
    parameter int DEPTH = DEF_Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_data,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_data
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### rtl/core/rgb2yuv_back.sv
// ----------------------------------------------------------------------------
// rgb2yuv_back
// Serializes each converted pixel into its Y and, where present, U and V
// results through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb2yuv_back
    import rgb2yuv_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    output logic    o_job_ready,
    input  t_job    i_job,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_job    r_job;
    logic    r_job_v;
    t_plane  r_phase;
    logic    r_out_v;
    t_result r_out;

    logic    slot_free, emit, last, job_done, pop;
    t_result n_out;

    assign slot_free = !r_out_v || i_ready;
    assign emit      = slot_free && r_job_v;
    assign last      = (r_phase == PLANE_V) || (r_phase == PLANE_Y && !r_job.chroma);
    assign job_done  = emit && last;
    assign pop       = i_job_valid && (!r_job_v || job_done);
    assign o_job_ready = !r_job_v || job_done;

    always_comb begin
        n_out.plane        = r_phase;
        n_out.last_of_item = last;
        n_out.frame_end    = r_job.frame_end;
        unique case (r_phase)
            PLANE_U: begin
                n_out.sample_value = r_job.u;
                n_out.plane_offset = LUMA_W'(r_job.chroma_off);
            end
            PLANE_V: begin
                n_out.sample_value = r_job.v;
                n_out.plane_offset = LUMA_W'(r_job.chroma_off);
            end
            default: begin
                n_out.sample_value = r_job.y;
                n_out.plane_offset = r_job.luma_off;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_phase <= PLANE_Y;
            r_out_v <= 1'b0;
        end else begin
            if (slot_free) begin
                r_out_v <= r_job_v;
            end
            if (pop) begin
                r_job_v <= 1'b1;
                r_phase <= PLANE_Y;
            end else if (job_done) begin
                r_job_v <= 1'b0;
            end else if (emit) begin
                r_phase <= (r_phase == PLANE_Y) ? PLANE_U : PLANE_V;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule

### rtl/core/rgb_to_yuv420_planar.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_planar
// RGB pixels in raster order to planar YUV 4:2:0 samples (BT.601, full range).
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel (i_valid/o_ready, i_pixel) takes one RGB pixel per transfer
//   in raster order. Result channel (o_valid/i_ready, o_result) gives one
//   sample per transfer: the Y sample of every pixel, then U and V for pixels
//   at even row and even column. last_of_item marks a pixel's final sample,
//   frame_end marks all samples of a frame's last pixel.
//   Path: products, sums, job queue, job register, then the output register.
//   Throughput: the output stage moves one sample per cycle while i_ready is
//   high; a pixel gives one sample on odd rows, one or three on even rows; a
//   pixel can be taken every cycle until the four-entry job queue fills.
//   Frame size is set over the APB port (frame_width at 0x0, frame_height at
//   0x4) and applies from the first pixel transfer after the write.
//   Reset clears position counters, pipeline and queue; size returns to
//   640x480. When the receiver stalls, the result is held, the queue fills
//   and o_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_yuv420_planar
    import rgb2yuv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int Q_DEPTH    = DEF_Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_pixel            i_pixel,
    output logic              o_valid,
    input  logic              i_ready,
    output t_result           o_result
);

`include "rgb_to_yuv420_planar_macros.svh"

    localparam logic [SIZE_W-1:0] MAX_W_C = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_C = SIZE_W'(MAX_HEIGHT);

    logic [CFG_W-1:0]  r_cfg_w, r_cfg_h;
    logic [SIZE_W-1:0] eff_w, eff_h;
    logic              wr_en;
    t_reg_idx          reg_idx;

    logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    t_job q_in_data, q_out_data;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    assign eff_w = eff_size(r_cfg_w, MAX_W_C);
    assign eff_h = eff_size(r_cfg_h, MAX_H_C);

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(r_cfg_w);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_cfg_h);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RESET_WIDTH;
            r_cfg_h <= RESET_HEIGHT;
        end else begin
            if (wr_en) begin
                unique case (reg_idx)
                    REG_FRAME_WIDTH:  r_cfg_w <= pwdata[CFG_W-1:0];
                    REG_FRAME_HEIGHT: r_cfg_h <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    rgb2yuv_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (eff_w),
        .i_height    (eff_h),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .o_job_valid (q_in_valid),
        .i_job_ready (q_in_ready),
        .o_job       (q_in_data)
    );

    rgb2yuv_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_in_valid),
        .o_push_ready (q_in_ready),
        .i_push_data  (q_in_data),
        .o_pop_valid  (q_out_valid),
        .i_pop_ready  (q_out_ready),
        .o_pop_data   (q_out_data)
    );

    rgb2yuv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_out_valid),
        .o_job_ready (q_out_ready),
        .i_job       (q_out_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

    // U is always followed at once by V of the same pixel
    `R2Y_ASSERT_NEXT(a_u_then_v, o_valid && i_ready && o_result.plane == PLANE_U,
        o_valid && o_result.plane == PLANE_V, "V sample did not follow U")
    `R2Y_ASSERT_IMPL(a_v_last, o_valid && o_result.plane == PLANE_V,
        o_result.last_of_item, "V sample not marked last of pixel")
    `R2Y_ASSERT_IMPL(a_chroma_off, o_valid && o_result.plane != PLANE_Y,
        o_result.plane_offset[LUMA_W-1:CHROMA_W] == '0, "chroma offset out of range")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: RGB to YUV 4:2:0 planar converter bench
// Streams pixels through the converter under several frame sizes and
// back-pressure patterns. A behavioral converter in the bench predicts every
// Y/U/V sample, and each sample transfer is checked against it in order.
// ----------------------------------------------------------------------------

module tb_top;
    import rgb2yuv_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int MAX_H       = DEF_MAX_HEIGHT;
    localparam int FLUSH_WAIT  = 16;
    localparam int CYCLE_LIMIT = 100000;
    localparam int PRINT_LIMIT = 40;

    // Q16 BT.601 full-range coefficients
    localparam int K_YR = 19595;
    localparam int K_YG = 38470;
    localparam int K_YB = 7471;
    localparam int K_UR = -11076;
    localparam int K_UG = -21758;
    localparam int K_UB = 32768;
    localparam int K_VR = 32768;
    localparam int K_VG = -27460;
    localparam int K_VB = -5308;
    localparam int CHROMA_BIAS = 128 * 65536;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_ready;
    t_pixel            i_pixel = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    t_result           o_result;

    rgb_to_yuv420_planar DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    t_pixel  pending_pixels[$];
    t_result expected_samples[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int err_cnt         = 0;
    int cycle_cnt       = 0;

    // Bench copy of the frame size registers and position counters
    logic [CFG_W-1:0]    cfg_width  = RESET_WIDTH;
    logic [CFG_W-1:0]    cfg_height = RESET_HEIGHT;
    int                  col_pos    = 0;
    int                  row_pos    = 0;
    logic [LUMA_W-1:0]   luma_ctr   = '0;
    logic [CHROMA_W-1:0] chroma_ctr = '0;

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= PRINT_LIMIT) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    function automatic int frame_dim(input logic [CFG_W-1:0] v, input int maxv);
        int s;
        s = int'(v);
        if (s < 2) s = 2;
        if (s > maxv) s = maxv;
        return s & ~1;
    endfunction

    function automatic logic [7:0] q16_to_byte(input int acc);
        int s;
        if (acc < 0) return 8'd0;
        s = acc >>> 16;
        return (s > 255) ? 8'd255 : 8'(s);
    endfunction

    // Predict the samples of one pixel and advance the raster position
    function automatic void convert_pixel(input t_pixel p);
        int      r, g, b, w, h;
        bit      row_end, fend, chroma;
        t_result res;
        r = int'(p.red);
        g = int'(p.green);
        b = int'(p.blue);
        w = frame_dim(cfg_width, MAX_W);
        h = frame_dim(cfg_height, MAX_H);
        row_end = (col_pos + 1 >= w);
        fend    = row_end && (row_pos + 1 >= h);
        chroma  = ((row_pos % 2) == 0) && ((col_pos % 2) == 0);

        res.plane        = PLANE_Y;
        res.sample_value = q16_to_byte(K_YR * r + K_YG * g + K_YB * b);
        res.plane_offset = luma_ctr;
        res.last_of_item = !chroma;
        res.frame_end    = fend;
        expected_samples.push_back(res);
        if (chroma) begin
            res.plane        = PLANE_U;
            res.sample_value = q16_to_byte(K_UR * r + K_UG * g + K_UB * b + CHROMA_BIAS);
            res.plane_offset = LUMA_W'(chroma_ctr);
            res.last_of_item = 1'b0;
            expected_samples.push_back(res);
            res.plane        = PLANE_V;
            res.sample_value = q16_to_byte(K_VR * r + K_VG * g + K_VB * b + CHROMA_BIAS);
            res.last_of_item = 1'b1;
            expected_samples.push_back(res);
            chroma_ctr++;
        end
        luma_ctr++;

        if (fend) begin
            col_pos    = 0;
            row_pos    = 0;
            luma_ctr   = '0;
            chroma_ctr = '0;
        end else if (row_end) begin
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
    endfunction

    // Pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                convert_pixel(i_pixel);
            end
            if (!i_valid || o_ready) begin
                if (pending_pixels.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    i_valid <= 1'b1;
                    i_pixel <= pending_pixels.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Sample monitor
    always @(posedge i_clk) begin : sample_mon
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_samples.size() == 0) begin
                flag_error($sformatf("unexpected sample transfer: plane %0d value %0d",
                                     o_result.plane, o_result.sample_value));
            end else begin
                want = expected_samples.pop_front();
                if (o_result.plane !== want.plane)
                    flag_error($sformatf("plane: got %0d exp %0d",
                                         o_result.plane, want.plane));
                if (o_result.sample_value !== want.sample_value)
                    flag_error($sformatf("sample_value (plane %0d off %0d): got %0d exp %0d",
                                         want.plane, want.plane_offset,
                                         o_result.sample_value, want.sample_value));
                if (o_result.plane_offset !== want.plane_offset)
                    flag_error($sformatf("plane_offset (plane %0d): got %0d exp %0d",
                                         want.plane, o_result.plane_offset,
                                         want.plane_offset));
                if (o_result.last_of_item !== want.last_of_item)
                    flag_error($sformatf("last_of_item (plane %0d off %0d): got %0b exp %0b",
                                         want.plane, want.plane_offset,
                                         o_result.last_of_item, want.last_of_item));
                if (o_result.frame_end !== want.frame_end)
                    flag_error($sformatf("frame_end (plane %0d off %0d): got %0b exp %0b",
                                         want.plane, want.plane_offset,
                                         o_result.frame_end, want.frame_end));
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // APB write, then read back over the same port
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        logic [ADDR_W-1:0] addr;
        addr = ADDR_W'(4 * int'(idx));
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // write lands on this edge; go straight into the read setup
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== DATA_W'(value[CFG_W-1:0]))
            flag_error($sformatf("register %s readback: got 0x%0h exp 0x%0h",
                                 idx.name(), prdata, value[CFG_W-1:0]));
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = value[CFG_W-1:0];
        else cfg_height = value[CFG_W-1:0];
    endtask

    task automatic set_frame_size(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    task automatic push_rgb(input int r, input int g, input int b);
        pending_pixels.push_back(t_pixel'{8'(r), 8'(g), 8'(b)});
    endtask

    // Block is idle once every pixel is taken and every sample has come back
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || i_valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (FLUSH_WAIT) @(posedge i_clk);
    endtask

    task automatic run_random(input int n, input int idle_pct, input int stall_pct);
        t_pixel p;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (n) begin
            p = t_pixel'(24'($urandom));
            // some pixels with saturated components to hit the clamps
            if ($urandom_range(7) == 0) begin
                p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
                p.green = $urandom_range(1) ? 8'hFF : 8'h00;
                p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            pending_pixels.push_back(p);
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size (640x480): primaries and extremes
        push_rgb(0, 0, 0);
        push_rgb(255, 255, 255);
        push_rgb(255, 0, 0);
        push_rgb(0, 255, 0);
        push_rgb(0, 0, 255);
        wait_drained();

        // Shrink to 4x4 mid-row: column is past the new width, so the row
        // closes on the next pixel
        set_frame_size(4, 4);
        push_rgb(255, 255, 0);
        push_rgb(0, 255, 255);
        push_rgb(255, 0, 255);
        push_rgb(128, 128, 128);
        push_rgb(8'h55, 8'hAA, 8'h55);
        push_rgb(8'hAA, 8'h55, 8'hAA);
        push_rgb(0, 0, 255);
        push_rgb(255, 0, 0);
        push_rgb(1, 2, 3);
        push_rgb(254, 253, 252);
        push_rgb(0, 128, 255);
        push_rgb(255, 128, 0);
        wait_drained();

        // Out-of-range sizes: below minimum, odd, and past the maximum
        set_frame_size(0, 1);
        push_rgb(10, 200, 30);
        push_rgb(240, 15, 99);
        push_rgb(255, 255, 255);
        push_rgb(0, 0, 0);
        wait_drained();

        set_frame_size(32'hFFFF_FFFF, 32'hFFFF_E003);
        push_rgb(77, 0, 255);
        push_rgb(0, 77, 0);
        push_rgb(255, 1, 128);
        push_rgb(3, 254, 60);
        wait_drained();

        // Random pixels under several sizes and flow-control patterns
        set_frame_size(6, 4);
        run_random(40, 0, 0);
        set_frame_size(2, 2);
        run_random(30, 66, 0);
        set_frame_size(10, 5);
        run_random(40, 0, 66);
        set_frame_size(4097, 4096);
        run_random(15, 6, 6);
        set_frame_size(4, 2);
        run_random(25, 6, 6);
        // sender held off until all samples are back, then resumes mid-frame
        run_random(10, 66, 66);

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
